>>> rtl/core/spectrum_top_k_bin_tracker_assert.svh
// ----------------------------------------------------------------------------
// Spectrum top-K bin tracker assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_TOP_K_BIN_TRACKER_ASSERT_SVH
`define SPECTRUM_TOP_K_BIN_TRACKER_ASSERT_SVH

// same-cycle implication
`define STKBT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stkbt: property failed");

// next-cycle implication
`define STKBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stkbt: property failed");

`endif

>>> rtl/core/stkbt_pkg.sv
// ----------------------------------------------------------------------------
// Spectrum top-K bin tracker package
// Fixed field widths and the saturating hit counter increment.
// ----------------------------------------------------------------------------
package stkbt_pkg;

  localparam int unsigned MAG_W     = 24;
  localparam int unsigned BIN_NUM_W = 9;
  localparam int unsigned RANK_W    = 2;
  localparam int unsigned HIT_W     = 32;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [HIT_W-1:0] hit_t;

  // hold at all ones, else advance by one
  function automatic hit_t sat_inc(hit_t v);
    return (v == {HIT_W{1'b1}}) ? v : v + hit_t'(1);
  endfunction

endpackage

>>> rtl/core/spectrum_top_k_bin_tracker.sv
// ----------------------------------------------------------------------------
// Spectrum top-K bin tracker
// Streaming top-K selection over spectrum bins with a per-bin hit histogram.
// ----------------------------------------------------------------------------
// Push one bin magnitude per word; bin indexes are counted inside, starting at
// 0 each frame and wrapping after BINS-1, and frame_end marks the last bin.
// The front end takes one word every cycle while full is low and keeps the
// TOP_K largest magnitudes of the frame in a sorted list (a strictly larger
// value enters, so on a tie the earlier bin ranks higher). On frame_end the
// finished list drops into a two-frame queue. The back end then, if the top
// entry's bin is nonzero, increments the saturating hit counter of every
// listed bin (unused slots count at bin 0), and pops TOP_K ranked result
// words, the last one with final_rank set. The back end takes a frame from
// the queue in its idle state, then, unless nothing is counted, reads and
// writes back the hit counter of each listed bin in turn through the
// separate read and write ports of the hit memory, then reads and presents
// the result of each rank while pop keeps up; frames with at least as many
// bins as the back end spends cycles on a counted frame stream at one word
// per cycle, shorter ones fill the queue and raise full. After reset the hit
// memory is zeroed bin by bin, during which full stays high.
// ----------------------------------------------------------------------------
module spectrum_top_k_bin_tracker import stkbt_pkg::*; #(
  parameter int unsigned BINS  = 512,
  parameter int unsigned TOP_K = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [MAG_W-1:0]     magnitude_i,
  input  logic                 frame_end_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [RANK_W-1:0]    rank_o,
  output logic [BIN_NUM_W-1:0] bin_number_o,
  output logic [MAG_W-1:0]     peak_value_o,
  output logic [HIT_W-1:0]     hit_total_o,
  output logic                 counted_o,
  output logic                 final_rank_o
);

  localparam int unsigned BIN_W  = $clog2(BINS);
  localparam int unsigned SNAP_W = TOP_K * (MAG_W + BIN_W);

  logic                     accept;
  logic                     snap_push;
  logic [TOP_K*MAG_W-1:0]   snap_mags;
  logic [TOP_K*BIN_W-1:0]   snap_bins;
  logic [SNAP_W-1:0]        q_head;
  logic                     q_full, q_empty, q_pop;
  logic                     clearing;
  logic                     res_pop;

  // hold off input while the queue is full or the hit memory is being zeroed
  assign full    = q_full | clearing;
  assign accept  = push & ~full;
  assign res_pop = pop & ~empty;

  stkbt_front #(
    .BINS  (BINS),
    .TOP_K (TOP_K)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .magnitude_i (magnitude_i),
    .frame_end_i (frame_end_i),
    .snap_push_o (snap_push),
    .snap_mags_o (snap_mags),
    .snap_bins_o (snap_bins)
  );

  stkbt_queue #(
    .WIDTH (SNAP_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  ({snap_mags, snap_bins}),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  stkbt_back #(
    .BINS  (BINS),
    .TOP_K (TOP_K)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_mags_i     (q_head[SNAP_W-1 -: TOP_K*MAG_W]),
    .q_bins_i     (q_head[TOP_K*BIN_W-1:0]),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .pop_i        (res_pop),
    .empty_o      (empty),
    .rank_o       (rank_o),
    .bin_number_o (bin_number_o),
    .peak_value_o (peak_value_o),
    .hit_total_o  (hit_total_o),
    .counted_o    (counted_o),
    .final_rank_o (final_rank_o)
  );

endmodule

>>> rtl/core/stkbt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data that holds when idle.
// ----------------------------------------------------------------------------
module stkbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/stkbt_front.sv
// ----------------------------------------------------------------------------
// Spectrum top-K bin tracker front end
// Counts bins, keeps the sorted top list and hands a snapshot on frame end.
// ----------------------------------------------------------------------------
module stkbt_front import stkbt_pkg::*; #(
  parameter int unsigned BINS  = 512,
  parameter int unsigned TOP_K = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [MAG_W-1:0]                   magnitude_i,
  input  logic                               frame_end_i,
  output logic                               snap_push_o,
  output logic [TOP_K*MAG_W-1:0]             snap_mags_o,
  output logic [TOP_K*$clog2(BINS)-1:0]      snap_bins_o
);

  localparam int unsigned BIN_W = $clog2(BINS);

  logic [BIN_W-1:0] bin_q, bin_d;
  mag_t             mag_q   [TOP_K];
  logic [BIN_W-1:0] idx_q   [TOP_K];
  mag_t             mag_ins [TOP_K];
  logic [BIN_W-1:0] idx_ins [TOP_K];
  logic [TOP_K-1:0] gt;

  // strictly greater only, so ties keep the earlier bin
  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      gt[i] = magnitude_i > mag_q[i];
    end
    mag_ins[0] = gt[0] ? magnitude_i : mag_q[0];
    idx_ins[0] = gt[0] ? bin_q : idx_q[0];
    for (int i = 1; i < TOP_K; i++) begin
      if (!gt[i]) begin
        mag_ins[i] = mag_q[i];
        idx_ins[i] = idx_q[i];
      end else if (!gt[i-1]) begin
        mag_ins[i] = magnitude_i;
        idx_ins[i] = bin_q;
      end else begin
        mag_ins[i] = mag_q[i-1];
        idx_ins[i] = idx_q[i-1];
      end
    end
    for (int i = 0; i < TOP_K; i++) begin
      snap_mags_o[i*MAG_W +: MAG_W] = mag_ins[i];
      snap_bins_o[i*BIN_W +: BIN_W] = idx_ins[i];
    end
  end

  assign bin_d       = (bin_q == BIN_W'(BINS - 1)) ? '0 : bin_q + BIN_W'(1);
  assign snap_push_o = accept_i & frame_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      for (int i = 0; i < TOP_K; i++) begin
        mag_q[i] <= '0;
        idx_q[i] <= '0;
      end
    end else if (accept_i) begin
      if (frame_end_i) begin
        bin_q <= '0;
        for (int i = 0; i < TOP_K; i++) begin
          mag_q[i] <= '0;
          idx_q[i] <= '0;
        end
      end else begin
        bin_q <= bin_d;
        for (int i = 0; i < TOP_K; i++) begin
          mag_q[i] <= mag_ins[i];
          idx_q[i] <= idx_ins[i];
        end
      end
    end
  end

endmodule

>>> rtl/core/stkbt_queue.sv
// ----------------------------------------------------------------------------
// Spectrum top-K bin tracker frame queue
// Two-entry FIFO of finished frame lists between front and back end.
// ----------------------------------------------------------------------------
module stkbt_queue #(
  parameter int unsigned WIDTH = 132
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

>>> rtl/core/stkbt_back.sv
// ----------------------------------------------------------------------------
// Spectrum top-K bin tracker back end
// Clears the hit memory, updates hit counters and emits ranked results.
// ----------------------------------------------------------------------------
module stkbt_back import stkbt_pkg::*; #(
  parameter int unsigned BINS  = 512,
  parameter int unsigned TOP_K = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  logic [TOP_K*MAG_W-1:0]        q_mags_i,
  input  logic [TOP_K*$clog2(BINS)-1:0] q_bins_i,
  output logic                          q_pop_o,
  output logic                          clearing_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [RANK_W-1:0]             rank_o,
  output logic [BIN_NUM_W-1:0]          bin_number_o,
  output logic [MAG_W-1:0]              peak_value_o,
  output logic [HIT_W-1:0]              hit_total_o,
  output logic                          counted_o,
  output logic                          final_rank_o
);

  localparam int unsigned BIN_W = $clog2(BINS);
  localparam int unsigned RW    = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  state_e           state_q;
  logic [RW-1:0]    r_q;
  logic [BIN_W-1:0] clr_q;
  logic             counted_q;
  logic             out_valid_q;
  logic [RANK_W-1:0]    rank_q;
  logic [BIN_NUM_W-1:0] bin_num_q;
  mag_t             peak_q;
  hit_t             hit_q;
  logic             counted_out_q;
  logic             final_q;

  logic [BIN_W-1:0] cur_bin;
  mag_t             cur_mag;
  logic             last_r;
  logic             out_free;
  logic             out_load;
  logic             ram_we, ram_re;
  logic [BIN_W-1:0] ram_waddr;
  hit_t             ram_wdata, ram_rdata;

  assign cur_bin  = q_bins_i[r_q*BIN_W +: BIN_W];
  assign cur_mag  = q_mags_i[r_q*MAG_W +: MAG_W];
  assign last_r   = r_q == RW'(TOP_K - 1);
  assign out_free = !out_valid_q || pop_i;
  assign out_load = (state_q == ST_OUT_LD) && out_free;

  assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_UPD_WR);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : cur_bin;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : sat_inc(ram_rdata);
  assign ram_re    = (state_q == ST_UPD_RD) || (state_q == ST_OUT_RD);

  assign q_pop_o    = out_load && last_r;
  assign clearing_o = state_q == ST_CLEAR;

  stkbt_ram #(
    .WIDTH (HIT_W),
    .DEPTH (BINS)
  ) u_hit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_bin),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      r_q           <= '0;
      clr_q         <= '0;
      counted_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      rank_q        <= '0;
      bin_num_q     <= '0;
      peak_q        <= '0;
      hit_q         <= '0;
      counted_out_q <= 1'b0;
      final_q       <= 1'b0;
    end else begin
      // drop the popped word unless a new one loads in its place
      if (pop_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + BIN_W'(1);
          if (clr_q == BIN_W'(BINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty_i) begin
            r_q       <= '0;
            counted_q <= q_bins_i[BIN_W-1:0] != '0;
            state_q   <= (q_bins_i[BIN_W-1:0] != '0) ? ST_UPD_RD : ST_OUT_RD;
          end
        end
        ST_UPD_RD: begin
          state_q <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          if (last_r) begin
            r_q     <= '0;
            state_q <= ST_OUT_RD;
          end else begin
            r_q     <= r_q + RW'(1);
            state_q <= ST_UPD_RD;
          end
        end
        ST_OUT_RD: begin
          state_q <= ST_OUT_LD;
        end
        ST_OUT_LD: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            rank_q        <= RANK_W'(r_q);
            bin_num_q     <= BIN_NUM_W'(cur_bin);
            peak_q        <= cur_mag;
            hit_q         <= ram_rdata;
            counted_out_q <= counted_q;
            final_q       <= last_r;
            if (last_r) begin
              state_q <= ST_IDLE;
            end else begin
              r_q     <= r_q + RW'(1);
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign empty_o      = !out_valid_q;
  assign rank_o       = rank_q;
  assign bin_number_o = bin_num_q;
  assign peak_value_o = peak_q;
  assign hit_total_o  = hit_q;
  assign counted_o    = counted_out_q;
  assign final_rank_o = final_q;

endmodule

>>> rtl/core/stkbt_checker.sv
// ----------------------------------------------------------------------------
// Spectrum top-K bin tracker checker
// Port-level properties on the result side, bound to the top level.
// ----------------------------------------------------------------------------
`include "spectrum_top_k_bin_tracker_assert.svh"

module stkbt_checker import stkbt_pkg::*; #(
  parameter int unsigned TOP_K = 4
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input logic [RANK_W-1:0]    rank_o,
  input logic [BIN_NUM_W-1:0] bin_number_o,
  input logic [MAG_W-1:0]     peak_value_o,
  input logic [HIT_W-1:0]     hit_total_o,
  input logic                 counted_o,
  input logic                 final_rank_o
);

  localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(TOP_K - 1);

  // a waiting word holds until popped
  `STKBT_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(peak_value_o) && $stable(rank_o))

  // the closing word of a frame carries the last rank
  `STKBT_ASSERT_IMPL(a_final_rank, !empty && final_rank_o, rank_o == RANK_LAST)

  // a counted frame has bumped every listed bin at least once
  `STKBT_ASSERT_IMPL(a_counted_hit, !empty && counted_o, hit_total_o != '0)

  // an uncounted frame has bin 0 on top
  `STKBT_ASSERT_IMPL(a_uncounted_top, !empty && !counted_o && rank_o == '0 && TOP_K <= 4, bin_number_o == '0)

endmodule

bind spectrum_top_k_bin_tracker stkbt_checker #(
  .TOP_K (TOP_K)
) u_stkbt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .rank_o       (rank_o),
  .bin_number_o (bin_number_o),
  .peak_value_o (peak_value_o),
  .hit_total_o  (hit_total_o),
  .counted_o    (counted_o),
  .final_rank_o (final_rank_o)
);
